// ----- design/tfn_pkg.sv -----
package tfn_pkg;

  localparam int unsigned VERTEX_SLOTS_DEF = 1024;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned POS_W = 16;
  localparam int unsigned NRM_W = 16;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_FACE = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                      command;
    logic [IDX_W-1:0]          corner_a;
    logic [IDX_W-1:0]          corner_b;
    logic [IDX_W-1:0]          corner_c;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]          vertex_index;
    logic signed [NRM_W-1:0]   normal_x;
    logic signed [NRM_W-1:0]   normal_y;
    logic signed [NRM_W-1:0]   normal_z;
    logic                      degenerate;
    logic                      last;
  } out_item_t;

  // One vertex position as held in the store: z, y, x from the top down.
  typedef logic [3*POS_W-1:0] vpos_t;

  // A face with its three positions fetched, handed from front to back.
  typedef struct packed {
    logic [2:0][IDX_W-1:0] idx;
    logic [2:0][3*POS_W-1:0] pos;
  } job_t;

endpackage

// ----- design/tfn_front.sv -----
module tfn_front #(
  parameter int unsigned VertexSlots = tfn_pkg::VERTEX_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  tfn_pkg::in_item_t in_item_i,
  output logic              job_push_o,
  input  logic              job_full_i,
  output tfn_pkg::job_t     job_o
);
  import tfn_pkg::*;

  localparam int unsigned AddrW = (VertexSlots > 1) ? $clog2(VertexSlots) : 1;
  localparam int unsigned CmpW  = 17;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_PUSH
  } state_e;

  state_e state_q;
  logic [1:0] cnt_q;

  logic [IDX_W-1:0] idx_q [3];
  vpos_t            pos_q [3];
  vpos_t            mem_q [VertexSlots];
  vpos_t            rdata_q;
  logic             rok_q;

  logic             accept;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic             wr_ok;
  logic [IDX_W-1:0] rd_idx;
  logic [AddrW-1:0] rd_addr;
  logic             rd_ok;
  logic             rd_en;

  assign full   = (state_q != ST_IDLE);
  assign accept = push && !full;

  always_comb begin
    wr_ok   = CmpW'(in_item_i.corner_a) < CmpW'(VertexSlots);
    wr_addr = AddrW'(CmpW'(in_item_i.corner_a));
    wr_en   = accept && (in_item_i.command == CMD_LOAD) && wr_ok;
    rd_idx  = (cnt_q == 2'd3) ? idx_q[0] : idx_q[cnt_q];
    rd_ok   = CmpW'(rd_idx) < CmpW'(VertexSlots);
    rd_addr = AddrW'(CmpW'(rd_idx));
    rd_en   = (state_q == ST_READ) && (cnt_q != 2'd3);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= {in_item_i.pos_z, in_item_i.pos_y, in_item_i.pos_x};
    end
    if (rd_en && rd_ok) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept && in_item_i.command == CMD_FACE) begin
            idx_q[0] <= in_item_i.corner_a;
            idx_q[1] <= in_item_i.corner_b;
            idx_q[2] <= in_item_i.corner_c;
            cnt_q    <= '0;
            state_q  <= ST_READ;
          end
        end
        ST_READ: begin
          rok_q <= rd_ok;
          // Read data lands in the cycle after its address was issued.
          if (cnt_q != 2'd0) begin
            pos_q[2'(cnt_q - 2'd1)] <= rok_q ? rdata_q : '0;
          end
          if (cnt_q == 2'd3) begin
            state_q <= ST_PUSH;
          end
          cnt_q <= cnt_q + 2'd1;
        end
        ST_PUSH: begin
          if (!job_full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign job_push_o = (state_q == ST_PUSH) && !job_full_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      job_o.idx[i] = idx_q[i];
      job_o.pos[i] = pos_q[i];
    end
  end

endmodule

// ----- design/tfn_queue.sv -----
module tfn_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tfn_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output tfn_pkg::job_t data_o,
  output logic          empty_o
);
  import tfn_pkg::*;

  job_t       slot_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i && !full_o) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i && !empty_o) begin
        rptr_q <= !rptr_q;
      end
      unique case ({push_i && !full_o, pop_i && !empty_o})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- design/tfn_back.sv -----
module tfn_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tfn_pkg::job_t      job_i,
  input  logic               job_empty_i,
  output logic               job_pop_o,
  output logic               empty,
  input  logic               pop,
  output tfn_pkg::out_item_t out_item_o
);
  import tfn_pkg::*;

  localparam logic [14:0] UnitOne = 15'd16384;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CROSS,
    ST_MAG,
    ST_SCALE,
    ST_SQUARE,
    ST_SQRT,
    ST_DINIT,
    ST_DSTEP
  } state_e;

  state_e state_q;
  logic   emit_q;
  logic [2:0] kc_q;
  logic [4:0] step_q;

  logic [IDX_W-1:0]    idx_q [3];
  logic signed [16:0]  e1_q [3];
  logic signed [16:0]  e2_q [3];
  logic signed [34:0]  cr_q [3];
  logic [34:0]         mag_q [3];
  logic [2:0]          neg_q;
  logic [63:0]         s_q;
  logic [63:0]         root_q;
  logic [63:0]         bit_q;
  logic [32:0]         rem_q;
  logic [15:0]         low_q;
  logic [15:0]         qq_q;
  logic [NRM_W-1:0]    nrm_q [3];
  logic                deg_q;

  logic signed [16:0] op_a, op_b;
  logic signed [33:0] prod;
  logic [34:0]        top;
  logic [61:0]        sq;
  logic [63:0]        rb;
  logic [45:0]        num;
  logic [33:0]        trial;
  logic               ge;
  logic [33:0]        tnext;
  logic [15:0]        qfin;
  logic [14:0]        qclamp;
  logic [31:0]        len;

  always_comb begin
    // Cross product terms, one product per cycle, even steps load, odd subtract.
    unique case (kc_q)
      3'd0:    begin op_a = e1_q[1]; op_b = e2_q[2]; end
      3'd1:    begin op_a = e1_q[2]; op_b = e2_q[1]; end
      3'd2:    begin op_a = e1_q[2]; op_b = e2_q[0]; end
      3'd3:    begin op_a = e1_q[0]; op_b = e2_q[2]; end
      3'd4:    begin op_a = e1_q[0]; op_b = e2_q[1]; end
      default: begin op_a = e1_q[1]; op_b = e2_q[0]; end
    endcase
    prod = op_a * op_b;

    top = mag_q[0];
    if (mag_q[1] > top) top = mag_q[1];
    if (mag_q[2] > top) top = mag_q[2];

    sq = mag_q[kc_q[1:0]][30:0] * mag_q[kc_q[1:0]][30:0];
    rb = root_q + bit_q;

    len    = root_q[31:0];
    num    = 46'({mag_q[kc_q[1:0]][30:0], 14'd0}) + 46'(len >> 1);
    trial  = {rem_q, low_q[15]};
    ge     = trial >= {2'b00, len};
    tnext  = ge ? (trial - {2'b00, len}) : trial;
    qfin   = {qq_q[14:0], ge};
    qclamp = (qfin > 16'(UnitOne)) ? UnitOne : qfin[14:0];
  end

  assign job_pop_o = (state_q == ST_IDLE) && !emit_q && !job_empty_i;
  assign empty     = !emit_q;

  always_comb begin
    out_item_o.vertex_index = idx_q[kc_q[1:0]];
    out_item_o.normal_x     = nrm_q[0];
    out_item_o.normal_y     = nrm_q[1];
    out_item_o.normal_z     = nrm_q[2];
    out_item_o.degenerate   = deg_q;
    out_item_o.last         = (kc_q == 3'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      emit_q  <= 1'b0;
      kc_q    <= '0;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (emit_q) begin
            if (pop) begin
              kc_q <= kc_q + 3'd1;
              if (kc_q == 3'd2) begin
                emit_q <= 1'b0;
              end
            end
          end else if (!job_empty_i) begin
            for (int i = 0; i < 3; i++) begin
              idx_q[i] <= job_i.idx[i];
              e1_q[i]  <= 17'(signed'(job_i.pos[1][16*i +: 16]))
                        - 17'(signed'(job_i.pos[0][16*i +: 16]));
              e2_q[i]  <= 17'(signed'(job_i.pos[2][16*i +: 16]))
                        - 17'(signed'(job_i.pos[0][16*i +: 16]));
            end
            deg_q   <= 1'b0;
            kc_q    <= '0;
            state_q <= ST_CROSS;
          end
        end
        ST_CROSS: begin
          if (!kc_q[0]) begin
            cr_q[kc_q[2:1]] <= 35'(prod);
          end else begin
            cr_q[kc_q[2:1]] <= cr_q[kc_q[2:1]] - 35'(prod);
          end
          kc_q <= kc_q + 3'd1;
          if (kc_q == 3'd5) begin
            state_q <= ST_MAG;
          end
        end
        ST_MAG: begin
          for (int i = 0; i < 3; i++) begin
            neg_q[i] <= cr_q[i][34];
            mag_q[i] <= cr_q[i][34] ? 35'(-cr_q[i]) : 35'(cr_q[i]);
          end
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          // One bit of normalizing shift per cycle until the top lies in [2^30, 2^31).
          if (top == '0) begin
            deg_q <= 1'b1;
            for (int i = 0; i < 3; i++) nrm_q[i] <= '0;
            kc_q    <= '0;
            emit_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else if (top[34:31] != '0) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
          end else if (!top[30]) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
          end else begin
            s_q     <= '0;
            root_q  <= '0;
            bit_q   <= 64'd1 << 62;
            kc_q    <= '0;
            state_q <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          s_q  <= s_q + 64'(sq);
          kc_q <= kc_q + 3'd1;
          if (kc_q == 3'd2) begin
            step_q  <= '0;
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (s_q >= rb) begin
            s_q    <= s_q - rb;
            root_q <= (root_q >> 1) + bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q  <= bit_q >> 2;
          step_q <= step_q + 5'd1;
          if (step_q == 5'd31) begin
            kc_q    <= '0;
            state_q <= ST_DINIT;
          end
        end
        ST_DINIT: begin
          rem_q   <= 33'(num >> 16);
          low_q   <= num[15:0];
          qq_q    <= '0;
          step_q  <= '0;
          state_q <= ST_DSTEP;
        end
        ST_DSTEP: begin
          rem_q  <= tnext[32:0];
          low_q  <= low_q << 1;
          qq_q   <= qfin;
          step_q <= step_q + 5'd1;
          if (step_q == 5'd15) begin
            nrm_q[kc_q[1:0]] <= neg_q[kc_q[1:0]] ? NRM_W'(-{1'b0, qclamp})
                                                 : NRM_W'({1'b0, qclamp});
            if (kc_q == 3'd2) begin
              kc_q    <= '0;
              emit_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              kc_q    <= kc_q + 3'd1;
              state_q <= ST_DINIT;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- design/triangle_face_normal_engine.sv -----
// Flat-shading face normal unit.
// Input channel (push/full): a load item writes one Q8.8 vertex position into
// the vertex store; a face item names three corners. A transfer happens when
// push is high and full is low. Loads are taken one per cycle while the front
// end is free; a face holds the front end while it fetches its three
// positions from the single-port store.
// Result channel (empty/pop): each face gives three results, corners a, b, c
// in order, all carrying the same Q1.14 normal, the third with last set; the
// normal is a unit vector, or zero for a degenerate face. A result transfers
// when pop is high and empty is low. The back end computes the cross product
// with one multiplier, normalizes one bit per cycle, then takes a bit-serial
// square root and three radix-2 divisions, one per normal component.
// A two-entry queue between front and back keeps loads and face fetches
// flowing meanwhile.
// When the receiver stalls, the result stays on the ports and the back end
// waits; the front end keeps taking items until the queue fills.
// Reset empties the queue and all control state; the vertex store is not
// cleared and must be written before a face reads it.
module triangle_face_normal_engine #(
  parameter int unsigned VertexSlots = tfn_pkg::VERTEX_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  tfn_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output tfn_pkg::out_item_t out_item_o
);
  import tfn_pkg::*;

  job_t job_in, job_out;
  logic job_push, job_full, job_pop, job_empty;

  tfn_front #(
    .VertexSlots(VertexSlots)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .job_push_o (job_push),
    .job_full_i (job_full),
    .job_o      (job_in)
  );

  tfn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  tfn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- design/tfn_checker.sv -----
module tfn_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input tfn_pkg::in_item_t  in_item_i,
  input logic               empty,
  input logic               pop,
  input tfn_pkg::out_item_t out_item_o
);
  import tfn_pkg::*;

  // A stalled result must stay put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("result changed while stalled");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.degenerate) |->
      (out_item_o.normal_x == '0 && out_item_o.normal_y == '0 &&
       out_item_o.normal_z == '0))
    else $error("degenerate face with nonzero normal");

  a_nondegen_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.degenerate) |->
      (out_item_o.normal_x != '0 || out_item_o.normal_y != '0 ||
       out_item_o.normal_z != '0))
    else $error("unit normal is zero");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |->
      (out_item_o.normal_x >= -16'sd16384 && out_item_o.normal_x <= 16'sd16384 &&
       out_item_o.normal_y >= -16'sd16384 && out_item_o.normal_y <= 16'sd16384 &&
       out_item_o.normal_z >= -16'sd16384 && out_item_o.normal_z <= 16'sd16384))
    else $error("normal component out of range");

endmodule

bind triangle_face_normal_engine tfn_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .in_item_i  (in_item_i),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);
